// ----- design/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and helpers of the rectangle fill canvas.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int CANVAS_SIDE = 128;
    localparam int COLOR_BITS  = 8;

    localparam int SIDE_BITS = (CANVAS_SIDE > 1) ? $clog2(CANVAS_SIDE) : 1;
    localparam int EDGE_W    = SIDE_BITS + 1;
    localparam int DEPTH     = CANVAS_SIDE * CANVAS_SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int PIX_W     = 3 * COLOR_BITS;
    localparam int SUM_W     = 9;   // 7-bit position plus 8-bit size

    typedef logic [EDGE_W-1:0]     t_edge;
    typedef logic [COLOR_BITS-1:0] t_comp;

    typedef enum logic {
        REQ_FILL = 1'b0,
        REQ_READ = 1'b1
    } t_req_type;

    typedef struct packed {
        logic       req_type;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] size_w;
        logic [7:0] size_h;
        logic [7:0] fill_red;
        logic [7:0] fill_green;
        logic [7:0] fill_blue;
    } t_req;

    typedef struct packed {
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
        logic [7:0] box_left;
        logic [7:0] box_top;
        logic [7:0] box_right;
        logic [7:0] box_bottom;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic fill_step;
        logic read;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic fill_empty;
        logic fill_last;
        logic out_free;
    } t_sts;

    // clamp an edge coordinate to the canvas side
    function automatic t_edge sat_side(input logic [SUM_W-1:0] v);
        t_edge r;
        if (32'(v) > CANVAS_SIDE) begin
            r = EDGE_W'(CANVAS_SIDE);
        end else begin
            r = EDGE_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- design/rfc_if.sv -----
// ----------------------------------------------------------------------------
// rfc_req_if / rfc_rsp_if
// Valid/ready channels for requests and results of the rectangle fill canvas.
// ----------------------------------------------------------------------------
interface rfc_req_if import rfc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rfc_rsp_if import rfc_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/rfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rfc_ctrl
// Sequencer: clearing pass, request intake, fill sweep, read, result load.
// ----------------------------------------------------------------------------
module rfc_ctrl import rfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_type,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_req_type == REQ_READ) ? ST_READ : ST_FILL;
                end
            end
            ST_FILL: begin
                // empty rectangle: skip straight to the result
                if (i_sts.fill_empty) begin
                    n_state = ST_RESP;
                end else begin
                    o_cmd.fill_step = 1'b1;
                    if (i_sts.fill_last) begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/rfc_dp.sv -----
// ----------------------------------------------------------------------------
// rfc_dp
// Canvas memory, bounding box, sweep counters and result register.
// ----------------------------------------------------------------------------
module rfc_dp import rfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  logic i_rsp_ready,
    output logic o_rsp_valid,
    output t_rsp o_rsp_data
);

    logic [PIX_W-1:0] mem [DEPTH];

    logic [ADDR_W-1:0]    r_clr;
    t_edge                r_left, r_top, r_right, r_bottom;
    logic                 r_type;
    t_edge                r_x0, r_y0, r_x1, r_y1;
    logic [SIDE_BITS-1:0] r_cx, r_cy;
    logic [ADDR_W-1:0]    r_base;
    logic [PIX_W-1:0]     r_col;
    logic                 r_rd_ok;
    logic [PIX_W-1:0]     r_rd;
    logic                 r_out_valid;
    t_rsp                 r_out;

    t_edge            w_x0, w_y0, w_x1, w_y1;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [PIX_W-1:0]  w_wdata;
    logic              w_row_end;
    t_comp             w_r, w_g, w_b;

    assign w_x0 = sat_side({2'b0, i_req_data.pos_x});
    assign w_y0 = sat_side({2'b0, i_req_data.pos_y});
    assign w_x1 = sat_side({2'b0, i_req_data.pos_x} + {1'b0, i_req_data.size_w});
    assign w_y1 = sat_side({2'b0, i_req_data.pos_y} + {1'b0, i_req_data.size_h});

    assign w_addr    = r_base + ADDR_W'(r_cx);
    assign w_row_end = ({1'b0, r_cx} == (r_x1 - EDGE_W'(1)));

    assign o_sts.clr_last   = (32'(r_clr) == DEPTH - 1);
    assign o_sts.fill_empty = (r_x0 >= r_x1) || (r_y0 >= r_y1);
    assign o_sts.fill_last  = w_row_end && ({1'b0, r_cy} == (r_y1 - EDGE_W'(1)));
    assign o_sts.out_free   = !r_out_valid || i_rsp_ready;

    // write port: clearing pass or fill sweep
    assign w_we    = i_cmd.clear || i_cmd.fill_step;
    assign w_waddr = i_cmd.clear ? r_clr : w_addr;
    assign w_wdata = i_cmd.clear ? {PIX_W{1'b1}} : r_col;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= mem[w_addr];
        end
    end

    // control state: clear counter, box, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_left      <= EDGE_W'(CANVAS_SIDE);
            r_top       <= EDGE_W'(CANVAS_SIDE);
            r_right     <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.accept && (i_req_data.req_type == REQ_FILL)) begin
                if (w_x0 < r_left)   r_left   <= w_x0;
                if (w_y0 < r_top)    r_top    <= w_y0;
                if (w_x1 > r_right)  r_right  <= w_x1;
                if (w_y1 > r_bottom) r_bottom <= w_y1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch and sweep counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type  <= i_req_data.req_type;
            r_x0    <= w_x0;
            r_y0    <= w_y0;
            r_x1    <= w_x1;
            r_y1    <= w_y1;
            r_cx    <= SIDE_BITS'(i_req_data.pos_x);
            r_cy    <= SIDE_BITS'(i_req_data.pos_y);
            r_base  <= ADDR_W'(32'(i_req_data.pos_y) * 32'(CANVAS_SIDE));
            r_col   <= {COLOR_BITS'(i_req_data.fill_red),
                        COLOR_BITS'(i_req_data.fill_green),
                        COLOR_BITS'(i_req_data.fill_blue)};
            r_rd_ok <= (32'(i_req_data.pos_x) < CANVAS_SIDE) &&
                       (32'(i_req_data.pos_y) < CANVAS_SIDE);
        end else if (i_cmd.fill_step) begin
            if (w_row_end) begin
                r_cx   <= SIDE_BITS'(r_x0);
                r_cy   <= r_cy + SIDE_BITS'(1);
                r_base <= r_base + ADDR_W'(CANVAS_SIDE);
            end else begin
                r_cx <= r_cx + SIDE_BITS'(1);
            end
        end
    end

    assign w_r = r_rd[3*COLOR_BITS-1:2*COLOR_BITS];
    assign w_g = r_rd[2*COLOR_BITS-1:COLOR_BITS];
    assign w_b = r_rd[COLOR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if ((r_type == REQ_READ) && r_rd_ok) begin
                r_out.pix_red   <= 8'(w_r);
                r_out.pix_green <= 8'(w_g);
                r_out.pix_blue  <= 8'(w_b);
            end else begin
                r_out.pix_red   <= '0;
                r_out.pix_green <= '0;
                r_out.pix_blue  <= '0;
            end
            r_out.box_left   <= 8'(r_left);
            r_out.box_top    <= 8'(r_top);
            r_out.box_right  <= 8'(r_right);
            r_out.box_bottom <= 8'(r_bottom);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

endmodule

// ----- design/rectangle_fill_canvas.sv -----
// ----------------------------------------------------------------------------
// rectangle_fill_canvas
// Square RGB canvas with solid rectangle fill, pixel read and bounding box.
// ----------------------------------------------------------------------------
// Sequence: a read passes the read state, then the result state; a fill sweeps
//   the painted rectangle row by row (or skips it when empty), then the result state.
// One transaction at a time: a new request is taken only after the result is
//   loaded, and loading waits while the previous result waits for the sink.
// Reset: box goes empty; a clearing pass then paints the canvas white, one
//   pixel per cycle (CANVAS_SIDE * CANVAS_SIDE = 16384 pixels), with ready low.
module rectangle_fill_canvas import rfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfc_req_if.sink   i_req,
    rfc_rsp_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    // Sequencer: owns the handshake on the request side and steps the datapath.
    rfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.data.req_type),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    assign i_req.ready = w_ready;

    // Datapath: canvas memory, box registers and the result register, which
    // holds a finished transaction until the sink takes it.
    rfc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data)
    );

    // Hold off requests for the whole clearing pass.
    a_no_req_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !i_req.ready)
        else $error("request port ready during clearing pass");

    // One transaction in flight: ready drops right after acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> !i_req.ready)
        else $error("ready still high after acceptance");

    // Never overwrite a result that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten");

    // At most one command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear, w_cmd.accept, w_cmd.fill_step, w_cmd.read,
                  w_cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule

// ----- bench/rfc_canvas_checker.sv -----
// ----------------------------------------------------------------------------
// rfc_canvas_checker
// Watches both channels of the rectangle fill canvas, keeps a shadow canvas
// and bounding box, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rfc_canvas_checker import rfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rfc_req_if   i_req,
    rfc_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    logic [PIX_W-1:0] canvas [DEPTH];
    int               box_l;
    int               box_t;
    int               box_r;
    int               box_b;
    t_rsp             rsp_due [$];
    int               fail_total = 0;

    function automatic int clip_to_side(input int v);
        return (v > CANVAS_SIDE) ? CANVAS_SIDE : v;
    endfunction

    // Paint or sample the shadow canvas and return the result the block owes.
    function automatic t_rsp apply_request(input t_req rq);
        t_rsp             r;
        int               x0;
        int               y0;
        int               x1;
        int               y1;
        logic [PIX_W-1:0] px;
        r = '0;
        if (rq.req_type == REQ_FILL) begin
            x0 = clip_to_side(int'(rq.pos_x));
            y0 = clip_to_side(int'(rq.pos_y));
            x1 = clip_to_side(int'(rq.pos_x) + int'(rq.size_w));
            y1 = clip_to_side(int'(rq.pos_y) + int'(rq.size_h));
            if (x0 < box_l) box_l = x0;
            if (y0 < box_t) box_t = y0;
            if (x1 > box_r) box_r = x1;
            if (y1 > box_b) box_b = y1;
            for (int y = y0; y < y1; y++) begin
                for (int x = x0; x < x1; x++) begin
                    canvas[y * CANVAS_SIDE + x] = {t_comp'(rq.fill_red),
                                                   t_comp'(rq.fill_green),
                                                   t_comp'(rq.fill_blue)};
                end
            end
        end else if (int'(rq.pos_x) < CANVAS_SIDE && int'(rq.pos_y) < CANVAS_SIDE) begin
            px = canvas[int'(rq.pos_y) * CANVAS_SIDE + int'(rq.pos_x)];
            r.pix_red   = 8'(px[2*COLOR_BITS +: COLOR_BITS]);
            r.pix_green = 8'(px[COLOR_BITS +: COLOR_BITS]);
            r.pix_blue  = 8'(px[0 +: COLOR_BITS]);
        end
        r.box_left   = 8'(box_l);
        r.box_top    = 8'(box_t);
        r.box_right  = 8'(box_r);
        r.box_bottom = 8'(box_b);
        return r;
    endfunction

    task automatic compare_field(input string tag, input int want, input int got);
        if (want != got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            foreach (canvas[k]) canvas[k] = '1;
            box_l = CANVAS_SIDE;
            box_t = CANVAS_SIDE;
            box_r = 0;
            box_b = 0;
            rsp_due.delete();
        end else begin
            // retire the result first: it belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (rsp_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, got);
                end else begin
                    want = rsp_due.pop_front();
                    compare_field("pix_red",    want.pix_red,    got.pix_red);
                    compare_field("pix_green",  want.pix_green,  got.pix_green);
                    compare_field("pix_blue",   want.pix_blue,   got.pix_blue);
                    compare_field("box_left",   want.box_left,   got.box_left);
                    compare_field("box_top",    want.box_top,    got.box_top);
                    compare_field("box_right",  want.box_right,  got.box_right);
                    compare_field("box_bottom", want.box_bottom, got.box_bottom);
                end
            end
            if (i_req.valid && i_req.ready) begin
                rsp_due.push_back(apply_request(i_req.data));
            end
        end
        o_pending    <= rsp_due.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- bench/tb_rectangle_fill_canvas.sv -----
// ----------------------------------------------------------------------------
// tb_rectangle_fill_canvas
// Drives fill and read transactions into the rectangle fill canvas with random
// gaps and back-pressure; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rectangle_fill_canvas;
    import rfc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RAND_ITEMS     = 1528;
    localparam int PHASES         = 8;
    localparam int SQUEEZE_PHASE  = 4;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 32;

    // Per-phase idle percentages; phase 0 and the tail run with no idling.
    localparam int SEND_GAP  [PHASES] = '{0, 30, 10, 60, 0, 85, 20, 0};
    localparam int RDY_STALL [PHASES] = '{0, 20, 50, 10, 70, 0, 90, 0};

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfc_req_if req_ch ();
    rfc_rsp_if rsp_ch ();

    int   mismatches;
    int   outstanding;

    int   send_gap_pct  = 25;
    int   rdy_stall_pct = 25;
    bit   quiet_tail    = 1'b0;
    bit   squeeze_rsp   = 1'b0;
    t_req last_fill;
    bit   have_fill     = 1'b0;
    int   items_sent    = 0;

    rectangle_fill_canvas u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rfc_canvas_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (mismatches),
        .o_pending    (outstanding)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial begin
        #(64'd32_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_req fill_req(input int x, input int y, input int w, input int h,
                                      input logic [23:0] rgb);
        t_req rq;
        rq.req_type = REQ_FILL;
        rq.pos_x    = 7'(x);
        rq.pos_y    = 7'(y);
        rq.size_w   = 8'(w);
        rq.size_h   = 8'(h);
        {rq.fill_red, rq.fill_green, rq.fill_blue} = rgb;
        return rq;
    endfunction

    // Size and colour are don't-care on a read; fill them with noise.
    function automatic t_req read_req(input int x, input int y);
        t_req rq;
        rq = fill_req(x, y, $urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom()));
        rq.req_type = REQ_READ;
        return rq;
    endfunction

    // Mostly tiny rectangles, some medium, a few using the full size field.
    function automatic int pick_extent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(0, 6);
        if (roll < 97) return $urandom_range(0, 24);
        return $urandom_range(0, 255);
    endfunction

    // Bias origins toward the right and bottom edges so clipping shows up often.
    function automatic int pick_origin();
        if ($urandom_range(0, 9) < 3) return $urandom_range(100, 127);
        return $urandom_range(0, 127);
    endfunction

    function automatic t_req make_random_req();
        t_req rq;
        int   roll;
        int   x;
        int   y;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            // large fill: both extents over the whole size field
            rq = fill_req(pick_origin(), pick_origin(), $urandom_range(0, 255),
                          $urandom_range(0, 255), 24'($urandom()));
        end else if (roll < 45) begin
            rq = fill_req(pick_origin(), pick_origin(), pick_extent(), pick_extent(),
                          24'($urandom()));
        end else if (roll < 80 && have_fill) begin
            // probe in and just around the last rectangle painted
            x = int'(last_fill.pos_x) +
                $urandom_range(0, (last_fill.size_w > 16) ? 17 : int'(last_fill.size_w) + 1);
            y = int'(last_fill.pos_y) +
                $urandom_range(0, (last_fill.size_h > 16) ? 17 : int'(last_fill.size_h) + 1);
            rq = read_req((x > 127) ? 127 : x, (y > 127) ? 127 : y);
        end else begin
            rq = read_req($urandom_range(0, 127), $urandom_range(0, 127));
        end
        return rq;
    endfunction

    // Offer one transaction, maybe after a random gap, and hold it until taken.
    task automatic push_req(input t_req rq);
        logic [63:0] noise;
        if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
            noise = {$urandom(), $urandom()};
            req_ch.valid <= 1'b0;
            req_ch.data  <= noise[$bits(t_req)-1:0];
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if (rq.req_type == REQ_FILL) begin
            last_fill = rq;
            have_fill = 1'b1;
        end
    endtask

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin : rsp_ready_drive
        int held;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_rsp) begin
                rsp_ch.ready <= 1'b0;
                held = 0;
                while (held < SQUEEZE_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                squeeze_rsp = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 99) < rdy_stall_pct) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_req rq;
        int   target;
        int   xe;
        int   ye;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The clearing pass after reset keeps ready low, so the
        // first transaction simply waits for it.
        push_req(read_req(0, 0));                          // white, empty box
        push_req(read_req(127, 127));
        push_req(fill_req(10, 20, 0, 5, 24'h102030));      // zero width: box only
        push_req(read_req(10, 20));
        push_req(fill_req(5, 100, 7, 0, 24'h405060));      // zero height: box only
        push_req(read_req(5, 100));
        push_req(fill_req(0, 0, 1, 1, 24'h000000));        // single pixel, black
        push_req(read_req(0, 0));
        push_req(read_req(1, 0));
        push_req(fill_req(120, 125, 128, 128, 24'h123456)); // runs past both edges
        push_req(read_req(127, 127));
        push_req(read_req(119, 127));
        push_req(fill_req(127, 127, 255, 255, 24'hFEDCBA)); // largest size field
        push_req(read_req(127, 127));
        push_req(fill_req(0, 0, 128, 128, 24'hAA55F0));    // whole canvas
        push_req(read_req(64, 64));
        push_req(fill_req(1, 2, 3, 4, 24'h00FF00));
        push_req(read_req(1, 2));                          // inside corners
        push_req(read_req(3, 5));
        push_req(read_req(4, 5));                          // just outside
        push_req(read_req(3, 6));
        push_req(fill_req(127, 0, 1, 128, 24'h0F0F0F));    // last column
        push_req(read_req(127, 64));
        push_req(read_req(126, 64));

        // Random part in phases with different idle mixes.
        for (int ph = 0; ph < PHASES; ph++) begin
            send_gap_pct  = SEND_GAP[ph];
            rdy_stall_pct = RDY_STALL[ph];
            quiet_tail    = (ph == PHASES - 1);
            if (ph == SQUEEZE_PHASE) begin
                squeeze_rsp = 1'b1;
            end
            target = items_sent + RAND_ITEMS / PHASES;
            while (items_sent < target) begin
                rq = make_random_req();
                push_req(rq);
                // now and then read back a small rectangle and the column and row
                // just past it, row by row
                if (rq.req_type == REQ_FILL && rq.size_w <= 6 && rq.size_h <= 6 &&
                    $urandom_range(0, 3) == 0) begin
                    xe = int'(rq.pos_x) + int'(rq.size_w);
                    ye = int'(rq.pos_y) + int'(rq.size_h);
                    if (xe > 127) xe = 127;
                    if (ye > 127) ye = 127;
                    for (int y = int'(rq.pos_y); y <= ye; y++) begin
                        for (int x = int'(rq.pos_x); x <= xe; x++) begin
                            push_req(read_req(x, y));
                        end
                    end
                end
            end
        end

        // Drop valid, let every result come back, then give stragglers time.
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
